// ===== rtl/descending_insertion_sorter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property templates for the descending insertion sorter checks.
// ----------------------------------------------------------------------------
`ifndef DESCENDING_INSERTION_SORTER_ASSERT_SVH
`define DESCENDING_INSERTION_SORTER_ASSERT_SVH

// same-cycle implication
`define DIS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("descending_insertion_sorter: check failed");

// next-cycle implication
`define DIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("descending_insertion_sorter: check failed");

`endif

// ===== rtl/dis_pkg.sv =====
// ----------------------------------------------------------------------------
// dis_pkg
// Types and constants shared by the descending insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package dis_pkg;

  localparam int DIS_DATA_W       = 32;
  localparam int DIS_MAX_ELEMENTS = 32;

  typedef logic signed [DIS_DATA_W-1:0] dis_data_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } dis_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/descending_insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// descending_insertion_sorter
// Insertion sorter, largest first, built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every cell compares
// its value with the new one at the same time, so items may follow back to
// back. The item with last set is inserted too and then the whole set leaves
// through cell 0, one result per cycle on result_valid_o, while busy stays
// high through the final result. Results cannot be stalled: each is shown
// for one cycle only.
// Values that arrive while all MAX_ELEMENTS cells are in use are dropped, and
// every result of that set carries overflow_o.
// ----------------------------------------------------------------------------
`default_nettype none

module descending_insertion_sorter #(
  parameter int MAX_ELEMENTS = dis_pkg::DIS_MAX_ELEMENTS
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  dis_pkg::dis_data_t value_i,
  input  wire               last_i,
  output logic              result_valid_o,
  output dis_pkg::dis_data_t sorted_value_o,
  output logic              final_res_o,
  output logic              overflow_o
);
  import dis_pkg::*;

  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic            dropped_q;

  logic            accept;
  logic            full;
  dis_ctl_t        ctl;
  dis_data_t       cell_value [MAX_ELEMENTS];
  logic            cell_stays [MAX_ELEMENTS];

  assign busy   = (state_q == ST_EMIT);
  assign accept = start && !busy;
  assign full   = (count_q == CW'(MAX_ELEMENTS));

  assign ctl.insert = accept && !full;
  assign ctl.shift  = busy;

  assign result_valid_o = busy;
  assign sorted_value_o = cell_value[0];
  assign final_res_o    = busy && (count_q == CW'(1));
  assign overflow_o     = dropped_q;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic      prev_stays;
    dis_data_t prev_value;
    dis_data_t next_value;

    if (i == 0) begin : g_head
      assign prev_stays = 1'b1;
      assign prev_value = value_i;
    end else begin : g_body
      assign prev_stays = cell_stays[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign next_value = cell_value[i];
    end else begin : g_link
      assign next_value = cell_value[i+1];
    end

    dis_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .in_value_i   (value_i),
      .occupied_i   (CW'(i) < count_q),
      .prev_stays_i (prev_stays),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .value_o      (cell_value[i]),
      .stays_o      (cell_stays[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (full) begin
              dropped_q <= 1'b1;
            end else begin
              count_q <= count_q + CW'(1);
            end
            if (last_i) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          count_q <= count_q - CW'(1);
          if (count_q == CW'(1)) begin
            state_q   <= ST_IDLE;
            dropped_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dis_cell.sv =====
// ----------------------------------------------------------------------------
// dis_cell
// One slot of the insertion chain: keeps its value, takes the new value, or
// takes a neighbor's value, and tells the next slot whether it keeps its own.
// ----------------------------------------------------------------------------
`default_nettype none

module dis_cell (
  input  wire              clk_i,
  input  dis_pkg::dis_ctl_t ctl_i,
  input  dis_pkg::dis_data_t in_value_i,
  input  wire              occupied_i,
  input  wire              prev_stays_i,
  input  dis_pkg::dis_data_t prev_value_i,
  input  dis_pkg::dis_data_t next_value_i,
  output dis_pkg::dis_data_t value_o,
  output logic             stays_o
);
  import dis_pkg::*;

  dis_data_t value_q;
  dis_data_t value_d;

  // equal values stay ahead of the new one
  assign stays_o = occupied_i && (value_q >= in_value_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctl_i.insert) begin
      if (!stays_o) begin
        value_d = prev_stays_i ? in_value_i : prev_value_i;
      end
    end else if (ctl_i.shift) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== rtl/dis_checker.sv =====
// ----------------------------------------------------------------------------
// dis_checker
// Port-level checks of the descending insertion sorter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "descending_insertion_sorter_assert.svh"

module dis_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               start,
  input wire               busy,
  input wire               last_i,
  input wire               result_valid_o,
  input wire               final_res_o
);

  `DIS_ASSERT_SAME(a_strobe_busy, result_valid_o, busy)
  `DIS_ASSERT_NEXT(a_close_starts_run, start && !busy && last_i, busy && result_valid_o)
  `DIS_ASSERT_SAME(a_final_strobed, final_res_o, result_valid_o)
  `DIS_ASSERT_NEXT(a_final_ends_run, result_valid_o && final_res_o, !busy)
  `DIS_ASSERT_NEXT(a_run_unbroken, result_valid_o && !final_res_o, result_valid_o)

endmodule

bind descending_insertion_sorter dis_checker u_dis_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .last_i         (last_i),
  .result_valid_o (result_valid_o),
  .final_res_o    (final_res_o)
);

`default_nettype wire
